// ===== sv/cst_pkg.sv =====
// cst_pkg: shared types, constants and cleaning/splitting functions
// for the comment-stripping tokenizer. No dependencies.
package cst_pkg;

    // longest reported word; longer words saturate and are flagged
    localparam int MAX_TOKEN_LENGTH = 65535;
    // word counter holds up to MAX_TOKEN_LENGTH + 1
    localparam int LEN_W            = $clog2(MAX_TOKEN_LENGTH + 2);
    localparam int OFF_W            = 32;
    localparam int TLEN_W           = 16;
    localparam int MAX_RESULTS      = 4;
    localparam int RES_CNT_W        = $clog2(MAX_RESULTS + 1);
    localparam int NUM_CAND         = 6;
    localparam int QUEUE_DEPTH      = 8;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_POUND  = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_BLOCK  = 2'd1,
        MODE_LINE   = 2'd2
    } mode_t;

    typedef struct packed {
        logic [OFF_W-1:0]  offset;
        logic [TLEN_W-1:0] length;
        logic              group_delim;
        logic              length_saturated;
        logic              file_done;
        logic              run_last;
    } token_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       next_cons;
        mode_t      mode;
    } clean_t;

    typedef struct packed {
        logic [OFF_W-1:0] start;
        logic [LEN_W-1:0] length;
        logic             zero_seen;
    } word_t;

    typedef struct packed {
        word_t  word;
        logic   flush_valid;
        token_t flush_tok;
        logic   group_valid;
        token_t group_tok;
    } feed_t;

    function automatic logic is_space(logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_VT ||
               b == CH_FF || b == CH_CR;
    endfunction

    function automatic logic is_group(logic [7:0] b);
        return b == CH_LPAREN || b == CH_RPAREN || b == CH_LBRACE || b == CH_RBRACE;
    endfunction

    function automatic logic is_delim(logic [7:0] b);
        return is_group(b) || b == CH_COMMA || b == CH_COLON || b == CH_SEMI ||
               b == CH_SLASH || b == CH_POUND || b == CH_LBRACK || b == CH_RBRACK ||
               b == CH_STAR || b == CH_QUOTE || b == CH_BSLASH;
    endfunction

    // word token for the pending word, length clamped
    function automatic token_t word_token(word_t w);
        token_t t;
        logic   sat;
        sat                = w.length > LEN_W'(MAX_TOKEN_LENGTH);
        t.offset           = w.start;
        t.length           = sat ? TLEN_W'(MAX_TOKEN_LENGTH) : TLEN_W'(w.length);
        t.group_delim      = 1'b0;
        t.length_saturated = sat;
        t.file_done        = 1'b0;
        t.run_last         = 1'b0;
        return t;
    endfunction

    // blank comment bytes, using one byte of lookahead
    function automatic clean_t clean_f(mode_t mode, logic [7:0] c, logic consumed,
                                       logic [7:0] nx);
        clean_t r;
        r.ch        = c;
        r.next_cons = 1'b0;
        r.mode      = mode;
        if (consumed) begin
            r.ch = CH_SPACE;
        end else begin
            unique case (mode)
                MODE_BLOCK: begin
                    r.ch = CH_SPACE;
                    if (c == CH_STAR && nx == CH_SLASH) begin
                        r.next_cons = 1'b1;
                        r.mode      = MODE_NORMAL;
                    end
                end
                MODE_LINE: begin
                    if (c == CH_LF || c == CH_CR) begin
                        r.mode = MODE_NORMAL;
                    end else begin
                        r.ch = CH_SPACE;
                    end
                end
                MODE_NORMAL: begin
                    if (c == CH_SLASH && nx == CH_STAR) begin
                        r.ch        = CH_SPACE;
                        r.next_cons = 1'b1;
                        r.mode      = MODE_BLOCK;
                    end else if (c == CH_SLASH && nx == CH_SLASH) begin
                        r.ch        = CH_SPACE;
                        r.next_cons = 1'b1;
                        r.mode      = MODE_LINE;
                    end else if (c == CH_POUND) begin
                        r.ch   = CH_SPACE;
                        r.mode = MODE_LINE;
                    end
                end
                default: begin
                    r.ch = c;
                end
            endcase
        end
        return r;
    endfunction

    // split one cleaned byte into words and group tokens
    function automatic feed_t feed_f(word_t w, logic [7:0] b, logic [OFF_W-1:0] pos);
        feed_t r;
        r.word                        = w;
        r.flush_valid                 = 1'b0;
        r.flush_tok                   = word_token(w);
        r.group_valid                 = 1'b0;
        r.group_tok.offset            = pos;
        r.group_tok.length            = TLEN_W'(1);
        r.group_tok.group_delim       = 1'b1;
        r.group_tok.length_saturated  = 1'b0;
        r.group_tok.file_done         = 1'b0;
        r.group_tok.run_last          = 1'b0;
        if (!w.zero_seen) begin
            if (b == CH_NUL) begin
                r.flush_valid    = w.length != '0;
                r.word.length    = '0;
                r.word.zero_seen = 1'b1;
            end else if (is_space(b) || is_delim(b)) begin
                r.flush_valid = w.length != '0;
                r.word.length = '0;
                r.group_valid = is_group(b);
            end else begin
                if (w.length == '0) begin
                    r.word.start = pos;
                end
                if (w.length <= LEN_W'(MAX_TOKEN_LENGTH)) begin
                    r.word.length = w.length + LEN_W'(1);
                end
            end
        end
        return r;
    endfunction

endpackage

// ===== sv/cst_lexer.sv =====
// cst_lexer: comment blanking and word splitting for one byte per transfer.
// Depends on cst_pkg.
module cst_lexer (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          xfer,
    input  logic [7:0]                                    in_byte,
    input  logic                                          last_byte,
    output cst_pkg::token_t [cst_pkg::MAX_RESULTS-1:0]    res,
    output logic [cst_pkg::RES_CNT_W-1:0]                 res_cnt
);
    import cst_pkg::*;

    mode_t            mode_reg,      mode_next;
    logic [7:0]       held_char_reg, held_char_next;
    logic             held_valid_reg, held_valid_next;
    logic             held_cons_reg, held_cons_next;
    logic [OFF_W-1:0] pos_reg,       pos_next;
    word_t            word_reg,      word_next;

    clean_t           cl_h, cl_l;
    feed_t            fd_h, fd_l;
    mode_t            mode_a;
    logic             cons_a;
    word_t            word_a;
    token_t           end_tok;
    token_t [NUM_CAND-1:0] cand;
    logic   [NUM_CAND-1:0] cand_valid;
    logic [RES_CNT_W-1:0]  n;

    // clean and split the held byte, then the final byte if this is the end
    always_comb begin
        cl_h   = clean_f(mode_reg, held_char_reg, held_cons_reg, in_byte);
        fd_h   = feed_f(word_reg, cl_h.ch, pos_reg - OFF_W'(1));
        mode_a = held_valid_reg ? cl_h.mode : mode_reg;
        cons_a = held_valid_reg & cl_h.next_cons;
        word_a = held_valid_reg ? fd_h.word : word_reg;

        cl_l = clean_f(mode_a, in_byte, cons_a, CH_NUL);
        fd_l = feed_f(word_a, cl_l.ch, pos_reg);

        end_tok.offset           = pos_reg + OFF_W'(1);
        end_tok.length           = '0;
        end_tok.group_delim      = 1'b0;
        end_tok.length_saturated = 1'b0;
        end_tok.file_done        = 1'b1;
        end_tok.run_last         = 1'b0;

        cand[0] = fd_h.flush_tok;
        cand[1] = fd_h.group_tok;
        cand[2] = fd_l.flush_tok;
        cand[3] = fd_l.group_tok;
        cand[4] = word_token(fd_l.word);
        cand[5] = end_tok;
        cand_valid[0] = held_valid_reg & fd_h.flush_valid;
        cand_valid[1] = held_valid_reg & fd_h.group_valid;
        cand_valid[2] = last_byte & fd_l.flush_valid;
        cand_valid[3] = last_byte & fd_l.group_valid;
        cand_valid[4] = last_byte & (fd_l.word.length != '0);
        cand_valid[5] = last_byte;
    end

    // pack the valid results in order
    always_comb begin
        res = '0;
        n   = '0;
        for (int i = 0; i < NUM_CAND; i++) begin
            if (cand_valid[i]) begin
                res[n[1:0]] = cand[i];
                n           = n + RES_CNT_W'(1);
            end
        end
        if (n != '0) begin
            res[n[1:0] - 2'd1].run_last = 1'b1;
        end
        res_cnt = xfer ? n : '0;
    end

    // state update per transfer; the final byte returns everything to reset
    always_comb begin
        mode_next       = mode_reg;
        held_char_next  = held_char_reg;
        held_valid_next = held_valid_reg;
        held_cons_next  = held_cons_reg;
        pos_next        = pos_reg;
        word_next       = word_reg;
        if (xfer) begin
            if (last_byte) begin
                mode_next       = MODE_NORMAL;
                held_char_next  = '0;
                held_valid_next = 1'b0;
                held_cons_next  = 1'b0;
                pos_next        = '0;
                word_next       = '0;
            end else begin
                mode_next       = mode_a;
                held_char_next  = in_byte;
                held_valid_next = 1'b1;
                held_cons_next  = cons_a;
                pos_next        = pos_reg + OFF_W'(1);
                word_next       = word_a;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_NORMAL;
            held_char_reg  <= '0;
            held_valid_reg <= 1'b0;
            held_cons_reg  <= 1'b0;
            pos_reg        <= '0;
            word_reg       <= '0;
        end else begin
            mode_reg       <= mode_next;
            held_char_reg  <= held_char_next;
            held_valid_reg <= held_valid_next;
            held_cons_reg  <= held_cons_next;
            pos_reg        <= pos_next;
            word_reg       <= word_next;
        end
    end

endmodule

// ===== sv/cst_queue.sv =====
// cst_queue: result queue taking up to four tokens per cycle, giving one while rd_ready is high.
// Depends on cst_pkg.
module cst_queue (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  cst_pkg::token_t [cst_pkg::MAX_RESULTS-1:0]    wr_tok,
    input  logic [cst_pkg::RES_CNT_W-1:0]                 wr_cnt,
    output logic                                          has_room,
    output logic                                          rd_valid,
    input  logic                                          rd_ready,
    output cst_pkg::token_t                               rd_tok
);
    import cst_pkg::*;

    token_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg,    cnt_next;
    logic                pop;

    // room for a full burst of results
    assign has_room = cnt_reg <= QCNT_W'(QUEUE_DEPTH - MAX_RESULTS);
    assign rd_valid = cnt_reg != '0;
    assign rd_tok   = mem_reg[rd_ptr_reg];
    assign pop      = rd_valid & rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(wr_cnt);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        cnt_next    = cnt_reg + QCNT_W'(wr_cnt) - QCNT_W'(pop);
    end

    // storage writes
    always_ff @(posedge aclk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (RES_CNT_W'(k) < wr_cnt) begin
                mem_reg[wr_ptr_reg + QPTR_W'(k)] <= wr_tok[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== sv/comment_strip_tokenizer.sv =====
// comment_strip_tokenizer: top level of the comment-stripping tokenizer.
// Depends on cst_pkg, cst_lexer and cst_queue.

// Takes one text byte per cycle, blanks block, line and pound comments with
// one byte of lookahead, and reports each word (offset, length) plus every
// ( ) { } as a one-byte token; the final byte also flushes the pending word
// and adds an end marker, then the block restarts at position 0. A byte is
// cleaned when the byte after it is transferred, or at once when it is the
// final byte; the results of each transfer (zero to four) are computed in
// the cycle of the transfer and enter an eight-entry queue that drains one
// token per cycle while m_ready is high. s_ready is low while fewer than
// four queue entries are free, so the sustained input rate is one byte per
// cycle as long as the token rate stays at or below one per cycle; a result
// can be taken in the cycle after the transfer that produces it.
module comment_strip_tokenizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_token_offset,
    output logic [15:0] m_token_length,
    output logic        m_group_delim,
    output logic        m_length_saturated,
    output logic        m_file_done,
    output logic        m_run_last
);
    import cst_pkg::*;

    logic                         xfer;
    token_t [MAX_RESULTS-1:0]     res;
    logic   [RES_CNT_W-1:0]       res_cnt;
    token_t                       out_tok;

    // input transfer
    assign xfer = s_valid & s_ready;

    cst_lexer u_lexer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .xfer      (xfer),
        .in_byte   (s_in_byte),
        .last_byte (s_last_byte),
        .res       (res),
        .res_cnt   (res_cnt)
    );

    cst_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_tok   (res),
        .wr_cnt   (res_cnt),
        .has_room (s_ready),
        .rd_valid (m_valid),
        .rd_ready (m_ready),
        .rd_tok   (out_tok)
    );

    // result fields
    assign m_token_offset     = out_tok.offset;
    assign m_token_length     = out_tok.length;
    assign m_group_delim      = out_tok.group_delim;
    assign m_length_saturated = out_tok.length_saturated;
    assign m_file_done        = out_tok.file_done;
    assign m_run_last         = out_tok.run_last;

endmodule
